>>> hw/rtl/triangle_scanline_span_core_macros.svh
// Assertion macros shared by the checker of the span core.
`ifndef TRIANGLE_SCANLINE_SPAN_CORE_MACROS_SVH
`define TRIANGLE_SCANLINE_SPAN_CORE_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define TSS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication with a fixed delay in cycles.
`define TSS_ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("delayed assertion failed");

`endif

>>> hw/rtl/tss_pkg.sv
package tss_pkg;

	typedef logic signed [11:0] coord_t;

	// Sideband that travels alongside the dividers.
	typedef struct packed {
		logic        ok;
		logic        exact;
		logic        long_zero;
		logic        long_neg;
		logic        short_neg;
		coord_t      xa;
		coord_t      xc;
		logic [23:0] color;
		logic        shade_neg;
		logic [10:0] shade_mag;
	} side_t;

	// One lane of the restoring divider.
	typedef struct packed {
		logic [11:0] rem;
		logic [23:0] nq;
		logic [11:0] d;
	} div_t;

	localparam int DivSteps      = 24;
	localparam int StepsPerStage = 4;
	localparam int DivStages     = DivSteps / StepsPerStage;
	localparam int Latency       = DivStages + 4;

	localparam logic [14:0] Recip3   = 15'd21846;
	localparam logic [7:0]  ShadeMul = 8'd255;
	localparam logic [13:0] Recip5   = 14'd13108;

	// One step of restoring division: shift in a numerator bit, subtract if it fits.
	function automatic div_t div_step(input div_t x);
		logic [12:0] t;
		div_t r;
		t = {x.rem, x.nq[23]};
		r = x;
		if (t >= {1'b0, x.d}) begin
			r.rem = 12'(t - {1'b0, x.d});
			r.nq  = {x.nq[22:0], 1'b1};
		end else begin
			r.rem = t[11:0];
			r.nq  = {x.nq[22:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/triangle_scanline_span_core.sv
// Scanline span core: one triangle and row is taken on every clock cycle in which start
// is high, and the result appears with done high for one cycle only. The pipeline is built
// around the two restoring dividers of the edge interpolation, which produce four quotient
// bits per stage over six stages, behind three setup stages and one output stage. busy is
// never raised, so a transaction is accepted whenever start is high, and the receiver must
// take each result in the cycle it is shown.
module triangle_scanline_span_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tss_pkg::coord_t      ax,
	input  tss_pkg::coord_t      ay,
	input  tss_pkg::coord_t      bx,
	input  tss_pkg::coord_t      by,
	input  tss_pkg::coord_t      cx,
	input  tss_pkg::coord_t      cy,
	input  logic [23:0]          color,
	input  logic [10:0]          row,
	output logic                 done,
	output logic                 draw,
	output tss_pkg::coord_t      start_x,
	output tss_pkg::coord_t      end_x,
	output logic [23:0]          shaded_color
);
	import tss_pkg::*;

	logic        valid_s3, div_valid;
	logic [23:0] nl_s3, ns_s3;
	logic [11:0] dl_s3, ds_s3, ql, qs;
	side_t       side_s3, div_side;

	// The pipeline never stalls.
	assign busy = 1'b0;

	tss_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by       (by),
		.cx       (cx),
		.cy       (cy),
		.color    (color),
		.row      (row),
		.valid_s3 (valid_s3),
		.nl_s3    (nl_s3),
		.dl_s3    (dl_s3),
		.ns_s3    (ns_s3),
		.ds_s3    (ds_s3),
		.side_s3  (side_s3)
	);

	tss_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.nl        (nl_s3),
		.dl        (dl_s3),
		.ns        (ns_s3),
		.ds        (ds_s3),
		.side_in   (side_s3),
		.out_valid (div_valid),
		.ql        (ql),
		.qs        (qs),
		.side_out  (div_side)
	);

	tss_span u_span (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (div_valid),
		.ql           (ql),
		.qs           (qs),
		.side         (div_side),
		.done         (done),
		.draw         (draw),
		.start_x      (start_x),
		.end_x        (end_x),
		.shaded_color (shaded_color)
	);

endmodule

>>> hw/rtl/tss_setup.sv
module tss_setup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  tss_pkg::coord_t      ax,
	input  tss_pkg::coord_t      ay,
	input  tss_pkg::coord_t      bx,
	input  tss_pkg::coord_t      by,
	input  tss_pkg::coord_t      cx,
	input  tss_pkg::coord_t      cy,
	input  logic [23:0]          color,
	input  logic [10:0]          row,
	output logic                 valid_s3,
	output logic [23:0]          nl_s3,
	output logic [11:0]          dl_s3,
	output logic [23:0]          ns_s3,
	output logic [11:0]          ds_s3,
	output tss_pkg::side_t       side_s3
);
	import tss_pkg::*;

	// Stage 1 registers.
	logic               valid_s1;
	logic signed [25:0] p1_s1, p2_s1;
	coord_t             xa_s1, ya_s1, xb_s1, yb_s1, xc_s1, yc_s1;
	logic [10:0]        row_s1;
	logic [23:0]        color_s1;
	logic               shn_s1;
	logic [27:0]        shp_s1;

	// Stage 2 registers.
	logic               valid_s2, ok_s2, exact_s2, lz_s2, shn_s2;
	logic signed [25:0] nl_s2, ns_s2;
	logic signed [12:0] dl_s2, ds_s2;
	coord_t             xa_s2, xc_s2;
	logic [23:0]        color_s2;
	logic [19:0]        sha_s2;

	// Stage 1: facing products, vertex sort and the divide by three of the x sum.
	logic signed [12:0] d1, d2, d3, d4;
	logic signed [25:0] p1, p2;
	coord_t             sxa, sya, sxb, syb, sxc, syc, tx, ty;
	logic signed [13:0] sum, smag;
	logic               sneg;

	always_comb begin
		d1 = $signed({cx[11], cx}) - $signed({ax[11], ax});
		d2 = $signed({cy[11], cy}) - $signed({by[11], by});
		d3 = $signed({cy[11], cy}) - $signed({ay[11], ay});
		d4 = $signed({cx[11], cx}) - $signed({bx[11], bx});
		p1 = d1 * d2;
		p2 = d3 * d4;
		tx = '0;
		ty = '0;
		sxa = ax; sya = ay; sxb = bx; syb = by; sxc = cx; syc = cy;
		if (syc < sya) begin
			tx = sxa; sxa = sxc; sxc = tx;
			ty = sya; sya = syc; syc = ty;
		end
		if (syb < syc) begin
			tx = sxb; sxb = sxc; sxc = tx;
			ty = syb; syb = syc; syc = ty;
		end
		if (syc < sya) begin
			tx = sxa; sxa = sxc; sxc = tx;
			ty = sya; sya = syc; syc = ty;
		end
		sum  = $signed({{2{ax[11]}}, ax}) + $signed({{2{bx[11]}}, bx})
			+ $signed({{2{cx[11]}}, cx});
		sneg = sum[13];
		smag = sneg ? -sum : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		p1_s1    <= p1;
		p2_s1    <= p2;
		xa_s1    <= sxa; ya_s1 <= sya;
		xb_s1    <= sxb; yb_s1 <= syb;
		xc_s1    <= sxc; yc_s1 <= syc;
		row_s1   <= row;
		color_s1 <= color;
		shn_s1   <= sneg;
		shp_s1   <= smag[12:0] * Recip3;
	end

	// Stage 2: cull and row test, edge deltas and the numerator products.
	logic signed [26:0] facing;
	logic signed [12:0] rowe, ya13, yb13, yc13, xa13, xb13, xc13;
	logic signed [12:0] dxl, yl, dxs, dys, ysv;
	logic               ok2;

	always_comb begin
		facing = $signed({p1_s1[25], p1_s1}) - $signed({p2_s1[25], p2_s1});
		rowe   = $signed({2'b00, row_s1});
		ya13   = $signed({ya_s1[11], ya_s1});
		yb13   = $signed({yb_s1[11], yb_s1});
		yc13   = $signed({yc_s1[11], yc_s1});
		xa13   = $signed({xa_s1[11], xa_s1});
		xb13   = $signed({xb_s1[11], xb_s1});
		xc13   = $signed({xc_s1[11], xc_s1});
		ok2    = facing[26] && (rowe >= ya13) && (rowe <= yb13);
		dxl    = xb13 - xa13;
		yl     = rowe - ya13;
		ysv    = rowe - yc13;
		if (rowe < yc13) begin
			dxs = xa13 - xc13;
			dys = ya13 - yc13;
		end else begin
			dxs = xb13 - xc13;
			dys = yb13 - yc13;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2    <= ok2;
		exact_s2 <= (rowe == yc13);
		lz_s2    <= (yb_s1 == ya_s1);
		nl_s2    <= dxl * yl;
		ns_s2    <= dxs * ysv;
		dl_s2    <= yb13 - ya13;
		ds_s2    <= dys;
		xa_s2    <= xa_s1;
		xc_s2    <= xc_s1;
		color_s2 <= color_s1;
		shn_s2   <= shn_s1;
		sha_s2   <= shp_s1[27:16] * ShadeMul;
	end

	// Stage 3: magnitudes and quotient signs for the dividers, shade divide by 320.
	logic [25:0] nlm, nsm;
	logic [12:0] dlm, dsm;

	always_comb begin
		nlm = nl_s2[25] ? 26'(-nl_s2) : 26'(nl_s2);
		nsm = ns_s2[25] ? 26'(-ns_s2) : 26'(ns_s2);
		dlm = dl_s2[12] ? 13'(-dl_s2) : 13'(dl_s2);
		dsm = ds_s2[12] ? 13'(-ds_s2) : 13'(ds_s2);
	end

	logic [27:0] shc;
	assign shc = sha_s2[19:6] * Recip5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		nl_s3             <= nlm[23:0];
		dl_s3             <= dlm[11:0];
		ns_s3             <= nsm[23:0];
		ds_s3             <= dsm[11:0];
		side_s3.ok        <= ok_s2;
		side_s3.exact     <= exact_s2;
		side_s3.long_zero <= lz_s2;
		side_s3.long_neg  <= nl_s2[25] ^ dl_s2[12];
		side_s3.short_neg <= ns_s2[25] ^ ds_s2[12];
		side_s3.xa        <= xa_s2;
		side_s3.xc        <= xc_s2;
		side_s3.color     <= color_s2;
		side_s3.shade_neg <= shn_s2;
		side_s3.shade_mag <= shc[26:16];
	end

endmodule

>>> hw/rtl/tss_div.sv
module tss_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [23:0]          nl,
	input  logic [11:0]          dl,
	input  logic [23:0]          ns,
	input  logic [11:0]          ds,
	input  tss_pkg::side_t       side_in,
	output logic                 out_valid,
	output logic [11:0]          ql,
	output logic [11:0]          qs,
	output tss_pkg::side_t       side_out
);
	import tss_pkg::*;

	logic  valid_q [DivStages];
	div_t  long_q  [DivStages];
	div_t  short_q [DivStages];
	side_t side_q  [DivStages];

	// Two restoring dividers, StepsPerStage quotient bits per stage.
	for (genvar i = 0; i < DivStages; i++) begin : g_stage
		logic  v_in;
		div_t  l_in, s_in, l_nx, s_nx;
		side_t sd_in;

		if (i == 0) begin : g_first
			assign v_in  = in_valid;
			assign l_in  = '{rem: '0, nq: nl, d: dl};
			assign s_in  = '{rem: '0, nq: ns, d: ds};
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = valid_q[i-1];
			assign l_in  = long_q[i-1];
			assign s_in  = short_q[i-1];
			assign sd_in = side_q[i-1];
		end

		always_comb begin
			l_nx = l_in;
			s_nx = s_in;
			for (int k = 0; k < StepsPerStage; k++) begin
				l_nx = div_step(l_nx);
				s_nx = div_step(s_nx);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[i] <= 1'b0;
			end else begin
				valid_q[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			long_q[i]  <= l_nx;
			short_q[i] <= s_nx;
			side_q[i]  <= sd_in;
		end
	end

	assign out_valid = valid_q[DivStages-1];
	assign ql        = long_q[DivStages-1].nq[11:0];
	assign qs        = short_q[DivStages-1].nq[11:0];
	assign side_out  = side_q[DivStages-1];

endmodule

>>> hw/rtl/tss_span.sv
module tss_span (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [11:0]          ql,
	input  logic [11:0]          qs,
	input  tss_pkg::side_t       side,
	output logic                 done,
	output logic                 draw,
	output tss_pkg::coord_t      start_x,
	output tss_pkg::coord_t      end_x,
	output logic [23:0]          shaded_color
);
	import tss_pkg::*;

	// Edge x values, span ordering and the shaded colour.
	logic signed [13:0] xa14, xc14, qlv, qsv, xl, xs, lo, hi;
	logic [23:0]        s24, spread;

	always_comb begin
		xa14 = $signed({{2{side.xa[11]}}, side.xa});
		xc14 = $signed({{2{side.xc[11]}}, side.xc});
		qlv  = $signed({2'b00, ql});
		qsv  = $signed({2'b00, qs});
		if (side.long_zero) begin
			xl = xa14;
		end else begin
			xl = side.long_neg ? (xa14 - qlv) : (xa14 + qlv);
		end
		if (side.exact) begin
			xs = xc14;
		end else begin
			xs = side.short_neg ? (xc14 - qsv) : (xc14 + qsv);
		end
		if (xs > xl) begin
			lo = xl;
			hi = xs;
		end else begin
			lo = xs;
			hi = xl;
		end
		s24    = side.shade_neg ? 24'(-{13'b0, side.shade_mag}) : {13'b0, side.shade_mag};
		spread = s24 + {s24[15:0], 8'h00} + {s24[7:0], 16'h0000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		draw         <= side.ok;
		start_x      <= side.ok ? lo[11:0] : '0;
		end_x        <= side.ok ? hi[11:0] : '0;
		shaded_color <= side.ok ? (side.color & spread) : '0;
	end

endmodule

>>> hw/rtl/tss_checker.sv
`include "triangle_scanline_span_core_macros.svh"

module tss_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 done,
	input  logic                 draw,
	input  tss_pkg::coord_t      start_x,
	input  tss_pkg::coord_t      end_x,
	input  logic [23:0]          shaded_color
);
	import tss_pkg::*;

	// Every accepted transaction yields its result after the fixed latency.
	`TSS_ASSERT_DELAY(a_latency, start && !busy, Latency, done)

	// A culled or uncovered triangle reports an all-zero result.
	`TSS_ASSERT_IMPL(a_zero_result, done && !draw, start_x == 0 && end_x == 0 && shaded_color == 0)

	// A drawn span is ordered, smaller endpoint first.
	`TSS_ASSERT_IMPL(a_span_order, done && draw, $signed(start_x) <= $signed(end_x))

	// A result is only shown if a transaction entered the latency earlier.
	`TSS_ASSERT_IMPL(a_no_invented, done, $past(start && !busy, Latency))

endmodule

bind triangle_scanline_span_core tss_checker u_tss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.draw         (draw),
	.start_x      (start_x),
	.end_x        (end_x),
	.shaded_color (shaded_color)
);
